// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash words, round helper functions, state types.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS    = 64;
	localparam int unsigned TOTAL_W   = 61;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef logic [WORD_W-1:0] word_t;

	// Top-level sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} state_t;

	// Control from sequencer to round unit
	typedef struct packed {
		logic start;
	} rnd_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rnd_sts_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (WORD_W - n));
	endfunction

endpackage

// ----- rtl/sha256_byte_stream_hasher_core.sv -----
// A byte that does not fill a block leaves the input open; a byte that fills
//   a block holds the input stalled while the round unit runs 64 rounds.
// A last item pads its final block or blocks at one byte per cycle with
//   one or two compressions, then gives 8 digest words over 8 transfers.
// Throughput is set by the single round unit: one round per cycle.
// Reset (arst_n low) loads the initial hash words and clears counts; no sweep.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher, top level
// Byte packing, padding sequencer, digest output over a valid/stall port.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	state_t st_q, st_d;
	logic [5:0]          fill_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                end_q;        // end marker taken, padding under way
	logic                fin_pend_q;   // padding done, finish after compress
	logic                pad_first_q;  // 0x80 not yet placed
	logic                len_blk_q;    // length field goes in this block
	logic                start_q;      // kick the round unit once block is full
	logic [2:0]          onum_q;
	word_t               blk_q   [BLK_WORDS];
	word_t               chain_q [8];
	word_t               sum     [8];
	rnd_ctl_t            rctl;
	rnd_sts_t            rsts;

	logic       acc, out_go, put, put_full;
	logic [7:0] put_byte;
	logic [63:0] bits;

	assign acc    = in_valid && !in_stall;
	assign out_go = out_valid && !out_stall;
	assign bits   = {total_q, 3'b000};

	// Byte selection for the packer
	always_comb begin
		put = 1'b0;
		put_byte = message_byte;
		case (st_q)
			ST_IDLE: put = acc && byte_present;
			ST_PAD: begin
				put = 1'b1;
				if (pad_first_q) put_byte = PAD_BYTE;
				else if (len_blk_q && fill_q >= LEN_POS)
					put_byte = bits[8*(7-fill_q[2:0]) +: 8];
				else put_byte = 8'h00;
			end
			default: put = 1'b0;
		endcase
		put_full = put && (fill_q == 6'd63);
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (put_full) st_d = ST_COMP;
				else if (acc && message_end) st_d = ST_PAD;
			end
			ST_PAD:  if (put_full) st_d = ST_COMP;
			ST_COMP: begin
				if (rsts.done) st_d = fin_pend_q ? ST_OUT
					: (end_q ? ST_PAD : ST_IDLE);
			end
			ST_OUT:  if (out_go && onum_q == 3'd7) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall   = (st_q != ST_IDLE);
		out_valid  = (st_q == ST_OUT);
		rctl.start = start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			fill_q      <= '0;
			total_q     <= '0;
			end_q       <= 1'b0;
			fin_pend_q  <= 1'b0;
			pad_first_q <= 1'b1;
			len_blk_q   <= 1'b0;
			start_q     <= 1'b0;
			onum_q      <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
		end else begin
			st_q    <= st_d;
			start_q <= put_full;
			if (put) fill_q <= fill_q + 6'd1;
			if (st_q == ST_IDLE && acc && byte_present) total_q <= total_q + 1'b1;
			if (st_q == ST_IDLE && acc && message_end) end_q <= 1'b1;
			// 0x80 before byte 56 leaves room for the length in this block
			if (st_q == ST_PAD) begin
				pad_first_q <= 1'b0;
				if (pad_first_q && fill_q < LEN_POS) len_blk_q <= 1'b1;
				if (put_full && len_blk_q && !pad_first_q) fin_pend_q <= 1'b1;
			end
			if (st_q == ST_COMP && rsts.done) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= sum[i];
				// 0x80 overflowed the last block: length goes in the next one
				if (end_q && !pad_first_q) len_blk_q <= 1'b1;
			end
			if (st_q == ST_OUT && out_go) begin
				onum_q <= onum_q + 3'd1;
				if (onum_q == 3'd7) begin
					end_q       <= 1'b0;
					fin_pend_q  <= 1'b0;
					pad_first_q <= 1'b1;
					len_blk_q   <= 1'b0;
					total_q     <= '0;
					fill_q      <= '0;
					for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
				end
			end
		end
	end

	// Block buffer byte write
	always_ff @(posedge clk) begin
		if (put) blk_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= put_byte;
	end

	sha_round_unit u_rnd (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (rctl),
		.blk   (blk_q),
		.chain (chain_q),
		.sum   (sum),
		.sts   (rsts)
	);

	assign digest_word = chain_q[onum_q];
	assign word_number = onum_q;
	assign final_word  = (onum_q == 3'd7);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsts.busy |-> in_stall && !out_valid) else $error("input open while hashing");
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> onum_q == 3'd0) else $error("digest starts off word 0");
	a_pad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> fill_q == 6'd0) else $error("digest with partial block");

endmodule

// ----- rtl/sha_round_unit.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle over 64 rounds, with a rolling 16-word
// message schedule, then a combinational chain-value add.
// ----------------------------------------------------------------------------
module sha_round_unit import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rnd_ctl_t ctl,
	input  word_t    blk   [BLK_WORDS],
	input  word_t    chain [8],
	output word_t    sum   [8],
	output rnd_sts_t sts
);

	logic        busy_q;
	logic        fin_q;
	logic [5:0]  rnd_q;
	word_t       w_q [BLK_WORDS];
	word_t       v_q [8];

	word_t s0, s1, w_new, t1, t2;

	// Schedule extension and round datapath
	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Round control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			w_q <= blk;
			v_q <= chain;
		end else if (busy_q) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BLK_WORDS-1] <= w_new;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) sum[i] = chain[i] + v_q[i];
	end

	assign sts.busy = busy_q;
	assign sts.done = fin_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("round unit restarted while busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(busy_q) && !busy_q) else $error("done without rounds");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> rnd_q == '0) else $error("round count off at end");

endmodule
